// File: hw/rtl/tmd_pkg.sv
// tmd_pkg: result record, kind codes and byte-reversal helpers for the TLV deframer.
// Used by tmd_front, tmd_fifo, the top level and the checker. No dependencies.
package tmd_pkg;

    localparam logic [2:0] KIND_HDR     = 3'd0;
    localparam logic [2:0] KIND_REC_HDR = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD = 3'd2;
    localparam logic [2:0] KIND_OVER    = 3'd3;
    localparam logic [2:0] KIND_BAD_LEN = 3'd4;

    localparam logic [31:0] HDR_BYTES = 32'd24;
    localparam logic [31:0] HDR_LAST  = 32'd23;
    localparam logic [31:0] POS_MAX   = 32'hFFFF_FFFF;
    localparam logic [2:0]  REC_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]         kind;
        logic               swapped;
        logic signed [31:0] msg_length;
        logic signed [31:0] version;
        logic signed [63:0] stamp;
        logic signed [63:0] sequence_res;
        logic signed [31:0] rec_type;
        logic signed [31:0] rec_length;
        logic [7:0]         payload_byte;
        logic               payload_last;
    } res_t;

    function automatic logic [31:0] rev32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [63:0] rev64(input logic [63:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24],
                x[39:32], x[47:40], x[55:48], x[63:56]};
    endfunction

endpackage

// File: hw/rtl/tmd_if.sv
// tmd_in_if / tmd_out_if: valid/ready channels of the TLV deframer.
// Depends on nothing; payload widths follow the byte stream and result record.
interface tmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       msg_start;

    modport source (output valid, output data_byte, output msg_start, input ready);
    modport sink   (input valid, input data_byte, input msg_start, output ready);
endinterface

interface tmd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic               swapped;
    logic signed [31:0] msg_length;
    logic signed [31:0] version;
    logic signed [63:0] stamp;
    logic signed [63:0] sequence_res;
    logic signed [31:0] rec_type;
    logic signed [31:0] rec_length;
    logic [7:0]         payload_byte;
    logic               payload_last;

    modport source (output valid, output kind, output swapped, output msg_length,
                    output version, output stamp, output sequence_res,
                    output rec_type, output rec_length, output payload_byte,
                    output payload_last, input ready);
    modport sink   (input valid, input kind, input swapped, input msg_length,
                    input version, input stamp, input sequence_res,
                    input rec_type, input rec_length, input payload_byte,
                    input payload_last, output ready);
endinterface

// File: hw/rtl/tlv_message_deframer_top.sv
// tlv_message_deframer_top: byte-serial TLV message deframer.
// Input channel in_ch carries one stream byte per transfer with a start mark on
// the first byte of each message. Output channel out_ch carries result records:
// the 24-byte header (reported on its last byte, byte-swapped when the version
// reads above 0xFFFF little-endian), each record header (type and length), each
// payload byte with a last mark, an over record for bytes outside a message or
// at/past the total length, and a bad-length record that ends the message.
// Header bytes other than the last and the first seven record-header bytes give
// no output transfer.
// Throughput: one byte per cycle while in_ch.ready is high; the parser
// updates all of its state for a byte in the cycle it is accepted.
// A result is written into the queue when its byte is transferred and is shown
// on out_ch once it is the head entry. A two-entry queue sits between parser
// and output: in_ch.ready drops only when both entries hold untaken results,
// so a stalled receiver backs up the input after two results.
// Reset (rst_n low, asynchronous) clears the queue and leaves the parser
// outside any message.
// Depends on tmd_pkg, tmd_if, tmd_front, tmd_fifo.
module tlv_message_deframer_top
    import tmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tmd_in_if.sink    in_ch,
    tmd_out_if.source out_ch
);

    logic take;
    logic res_valid;
    logic full;
    res_t res;
    res_t head;

    assign in_ch.ready = !full;
    assign take        = in_ch.valid && !full;

    tmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (in_ch.data_byte),
        .msg_start (in_ch.msg_start),
        .res_valid (res_valid),
        .res       (res)
    );

    tmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && res_valid),
        .push_data (res),
        .full      (full),
        .pop_valid (out_ch.valid),
        .pop_ready (out_ch.ready),
        .pop_data  (head)
    );

    assign out_ch.kind         = head.kind;
    assign out_ch.swapped      = head.swapped;
    assign out_ch.msg_length   = head.msg_length;
    assign out_ch.version      = head.version;
    assign out_ch.stamp        = head.stamp;
    assign out_ch.sequence_res = head.sequence_res;
    assign out_ch.rec_type     = head.rec_type;
    assign out_ch.rec_length   = head.rec_length;
    assign out_ch.payload_byte = head.payload_byte;
    assign out_ch.payload_last = head.payload_last;

endmodule

// File: hw/rtl/tmd_front.sv
// tmd_front: per-byte parser. Holds message state, classifies each accepted byte
// and emits at most one result record per byte. Depends on tmd_pkg.
module tmd_front
    import tmd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] data_byte,
    input  logic       msg_start,
    output logic       res_valid,
    output res_t       res
);

    logic        active_reg, active_next;
    logic [31:0] byte_pos_reg, byte_pos_next;
    logic        swapped_reg, swapped_next;
    logic [63:0] shift_acc_reg, shift_acc_next;
    logic [31:0] hdr_length_reg, hdr_length_next;
    logic [31:0] hdr_version_reg, hdr_version_next;
    logic [63:0] hdr_stamp_reg, hdr_stamp_next;
    logic [31:0] cur_type_reg, cur_type_next;
    logic [31:0] payload_left_reg, payload_left_next;
    logic [2:0]  rec_idx_reg, rec_idx_next;

    // state as seen by this byte: a start mark wipes the running message
    logic        act_c;
    logic [31:0] pos_c, len_c, ver_c, type_c, left_c;
    logic        swp_c;
    logic [63:0] acc_c, stamp_c;
    logic [2:0]  idx_c;
    logic [31:0] rec_len;
    logic [31:0] len_out, ver_out;
    logic [63:0] stamp_out, seq_out;

    always_comb
    begin
        act_c   = msg_start | active_reg;
        pos_c   = msg_start ? '0 : byte_pos_reg;
        len_c   = msg_start ? '0 : hdr_length_reg;
        ver_c   = msg_start ? '0 : hdr_version_reg;
        stamp_c = msg_start ? '0 : hdr_stamp_reg;
        acc_c   = msg_start ? '0 : shift_acc_reg;
        swp_c   = msg_start ? 1'b0 : swapped_reg;
        type_c  = msg_start ? '0 : cur_type_reg;
        left_c  = msg_start ? '0 : payload_left_reg;
        idx_c   = msg_start ? '0 : rec_idx_reg;

        active_next       = act_c;
        byte_pos_next     = pos_c;
        hdr_length_next   = len_c;
        hdr_version_next  = ver_c;
        hdr_stamp_next    = stamp_c;
        shift_acc_next    = acc_c;
        swapped_next      = swp_c;
        cur_type_next     = type_c;
        payload_left_next = left_c;
        rec_idx_next      = idx_c;
        rec_len           = {data_byte, acc_c[23:0]};
        len_out           = '0;
        ver_out           = '0;
        stamp_out         = '0;
        seq_out           = '0;

        res       = '0;
        res_valid = 1'b0;

        if (!act_c)
        begin
            res.kind  = KIND_OVER;
            res_valid = 1'b1;
        end
        else
        begin
            byte_pos_next = (pos_c == POS_MAX) ? pos_c : pos_c + 32'd1;
            if (pos_c < HDR_BYTES)
            begin
                if (pos_c < 32'd4)
                begin
                    hdr_length_next[{pos_c[1:0], 3'b000} +: 8] = data_byte;
                end
                else if (pos_c < 32'd8)
                begin
                    hdr_version_next[{pos_c[1:0], 3'b000} +: 8] = data_byte;
                    // version above 0xFFFF once its top byte lands
                    if (pos_c[1:0] == 2'd3)
                    begin
                        swapped_next = (data_byte != 8'd0) || (ver_c[23:16] != 8'd0);
                    end
                end
                else if (pos_c < 32'd16)
                begin
                    hdr_stamp_next[{pos_c[2:0], 3'b000} +: 8] = data_byte;
                end
                else
                begin
                    shift_acc_next[{pos_c[2:0], 3'b000} +: 8] = data_byte;
                end

                if (pos_c == HDR_LAST)
                begin
                    len_out   = swp_c ? rev32(hdr_length_next) : hdr_length_next;
                    ver_out   = swp_c ? rev32(hdr_version_next) : hdr_version_next;
                    stamp_out = swp_c ? rev64(hdr_stamp_next) : hdr_stamp_next;
                    seq_out   = swp_c ? rev64(shift_acc_next) : shift_acc_next;
                    hdr_length_next  = len_out;
                    hdr_version_next = ver_out;
                    hdr_stamp_next   = stamp_out;
                    shift_acc_next   = '0;
                    res.kind         = KIND_HDR;
                    res.swapped      = swp_c;
                    res.msg_length   = len_out;
                    res.version      = ver_out;
                    res.stamp        = stamp_out;
                    res.sequence_res = seq_out;
                    res_valid        = 1'b1;
                end
            end
            else
            begin
                res.swapped = swp_c;
                res_valid   = 1'b1;
                if (len_c[31] || (pos_c >= len_c))
                begin
                    res.kind = KIND_OVER;
                end
                else if (left_c != 32'd0)
                begin
                    res.kind          = KIND_PAYLOAD;
                    res.payload_byte  = data_byte;
                    res.payload_last  = (left_c == 32'd1);
                    payload_left_next = left_c - 32'd1;
                end
                else if (idx_c != REC_LAST)
                begin
                    if (idx_c == 3'd0)
                    begin
                        cur_type_next = {24'd0, data_byte};
                    end
                    else if (!idx_c[2])
                    begin
                        cur_type_next[{idx_c[1:0], 3'b000} +: 8] = data_byte;
                    end
                    else if (idx_c == 3'd4)
                    begin
                        shift_acc_next = {56'd0, data_byte};
                    end
                    else
                    begin
                        shift_acc_next[{idx_c[1:0], 3'b000} +: 8] = data_byte;
                    end
                    rec_idx_next = idx_c + 3'd1;
                    res_valid    = 1'b0;
                end
                else
                begin
                    if (swp_c)
                    begin
                        rec_len       = rev32(rec_len);
                        cur_type_next = rev32(type_c);
                    end
                    rec_idx_next   = '0;
                    shift_acc_next = '0;
                    res.rec_type   = cur_type_next;
                    res.rec_length = rec_len;
                    if (rec_len[31])
                    begin
                        res.kind    = KIND_BAD_LEN;
                        active_next = 1'b0;
                    end
                    else
                    begin
                        res.kind          = KIND_REC_HDR;
                        payload_left_next = rec_len;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            byte_pos_reg     <= '0;
            swapped_reg      <= 1'b0;
            shift_acc_reg    <= '0;
            hdr_length_reg   <= '0;
            hdr_version_reg  <= '0;
            hdr_stamp_reg    <= '0;
            cur_type_reg     <= '0;
            payload_left_reg <= '0;
            rec_idx_reg      <= '0;
        end
        else if (take)
        begin
            active_reg       <= active_next;
            byte_pos_reg     <= byte_pos_next;
            swapped_reg      <= swapped_next;
            shift_acc_reg    <= shift_acc_next;
            hdr_length_reg   <= hdr_length_next;
            hdr_version_reg  <= hdr_version_next;
            hdr_stamp_reg    <= hdr_stamp_next;
            cur_type_reg     <= cur_type_next;
            payload_left_reg <= payload_left_next;
            rec_idx_reg      <= rec_idx_next;
        end
    end

endmodule

// File: hw/rtl/tmd_fifo.sv
// tmd_fifo: two-entry result queue between the parser and the output channel.
// Entries are registers; the head entry drives the output. Depends on tmd_pkg.
module tmd_fifo
    import tmd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic full,
    output logic pop_valid,
    input  logic pop_ready,
    output res_t pop_data
);

    res_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = mem[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/tmd_checker.sv
// tmd_checker: port-level checks for the TLV deframer, bound to the top level.
// Depends on tmd_pkg and the top level's interface ports.
module tmd_checker
    import tmd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [31:0] msg_length,
    input logic [31:0] rec_type,
    input logic        payload_last,
    input logic [7:0]  payload_byte
);

    // a stalled result must not change under the receiver
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(msg_length)
            && $stable(rec_type) && $stable(payload_byte))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_HDR) || (kind == KIND_REC_HDR)
            || (kind == KIND_PAYLOAD) || (kind == KIND_OVER) || (kind == KIND_BAD_LEN))
        else $error("result kind out of range");

    a_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_PAYLOAD) |-> !payload_last && (payload_byte == 8'd0))
        else $error("payload fields set on a non-payload result");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_HDR) |-> (msg_length == 32'd0)
            && ((kind == KIND_REC_HDR) || (kind == KIND_BAD_LEN) || (rec_type == 32'd0)))
        else $error("header or record fields set on the wrong result kind");

endmodule

bind tlv_message_deframer_top tmd_checker u_tmd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .kind         (out_ch.kind),
    .msg_length   (out_ch.msg_length),
    .rec_type     (out_ch.rec_type),
    .payload_last (out_ch.payload_last),
    .payload_byte (out_ch.payload_byte)
);

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for tlv_message_deframer_top, byte stream in, result records out.
// Uses tmd_pkg (res_t, kind codes, header constants) and the tmd_in_if / tmd_out_if channels.
// A byte-level parser model predicts every result; a monitor checks each output transfer.
module tb_top;
    import tmd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] SWAP_LIMIT   = 32'h0000_FFFF;
    localparam int          RANDOM_BYTES = 780;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 400_000;

    logic clk = 1'b0;
    logic rst_n;
    logic sink_rdy = 1'b0;

    tmd_in_if  in_ch ();
    tmd_out_if out_ch ();

    assign out_ch.ready = sink_rdy;

    tlv_message_deframer_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // parser model state
    logic        msg_open     = 1'b0;
    logic [31:0] msg_pos      = '0;
    logic        msg_swapped  = 1'b0;
    logic [63:0] gather_acc   = '0;
    logic [31:0] hdr_len      = '0;
    logic [31:0] hdr_ver      = '0;
    logic [63:0] hdr_stamp    = '0;
    logic [31:0] rec_type_acc = '0;
    logic [31:0] payload_due  = '0;
    logic [2:0]  rec_idx      = '0;

    res_t        due_results[$];
    logic [7:0]  frame_q[$];

    int          err_count     = 0;
    int          bytes_sent    = 0;
    int          results_seen  = 0;
    int          messages_sent = 0;
    int          cycle_count   = 0;
    int unsigned sink_hold     = 0;
    bit          src_idle_on   = 1'b1;
    bit          sink_stalls   = 1'b1;

    function automatic logic [31:0] flip32(input logic [31:0] x);
        logic [31:0] r;
        for (int i = 0; i < 4; i++)
            r[8*i +: 8] = x[8*(3-i) +: 8];
        return r;
    endfunction

    function automatic logic [63:0] flip64(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++)
            r[8*i +: 8] = x[8*(7-i) +: 8];
        return r;
    endfunction

    // Advances the parser model by one byte; returns 1 when the byte yields a result.
    function automatic bit parse_byte(input logic [7:0] b, input logic st, output res_t r);
        logic [31:0] p;
        logic [31:0] len;
        r = '0;
        if (st)
        begin
            msg_open     = 1'b1;
            msg_pos      = '0;
            msg_swapped  = 1'b0;
            gather_acc   = '0;
            hdr_len      = '0;
            hdr_ver      = '0;
            hdr_stamp    = '0;
            rec_type_acc = '0;
            payload_due  = '0;
            rec_idx      = '0;
        end
        if (!msg_open)
        begin
            r.kind = KIND_OVER;
            return 1'b1;
        end

        p = msg_pos;
        if (msg_pos != POS_MAX)
            msg_pos++;

        if (p < HDR_BYTES)
        begin
            if (p < 4)
                hdr_len |= {24'd0, b} << (8 * p);
            else if (p < 8)
            begin
                hdr_ver |= {24'd0, b} << (8 * (p - 4));
                if (p == 7)
                    msg_swapped = hdr_ver > SWAP_LIMIT;
            end
            else if (p < 16)
                hdr_stamp |= {56'd0, b} << (8 * (p - 8));
            else
                gather_acc |= {56'd0, b} << (8 * (p - 16));
            if (p != HDR_LAST)
                return 1'b0;
            if (msg_swapped)
            begin
                hdr_len    = flip32(hdr_len);
                hdr_ver    = flip32(hdr_ver);
                hdr_stamp  = flip64(hdr_stamp);
                gather_acc = flip64(gather_acc);
            end
            r.kind         = KIND_HDR;
            r.swapped      = msg_swapped;
            r.msg_length   = hdr_len;
            r.version      = hdr_ver;
            r.stamp        = hdr_stamp;
            r.sequence_res = gather_acc;
            gather_acc     = '0;
            return 1'b1;
        end

        r.swapped = msg_swapped;

        // negative total length puts every byte past the end
        if (hdr_len[31] || p >= hdr_len)
        begin
            r.kind = KIND_OVER;
            return 1'b1;
        end

        if (payload_due != 0)
        begin
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            r.payload_last = (payload_due == 32'd1);
            payload_due--;
            return 1'b1;
        end

        if (rec_idx < 4)
        begin
            if (rec_idx == 0)
                rec_type_acc = '0;
            rec_type_acc |= {24'd0, b} << (8 * rec_idx);
        end
        else
        begin
            if (rec_idx == 4)
                gather_acc = '0;
            gather_acc |= {56'd0, b} << (8 * (rec_idx - 4));
        end

        if (rec_idx != REC_LAST)
        begin
            rec_idx++;
            return 1'b0;
        end

        len = gather_acc[31:0];
        if (msg_swapped)
        begin
            len          = flip32(len);
            rec_type_acc = flip32(rec_type_acc);
        end
        rec_idx      = '0;
        gather_acc   = '0;
        r.rec_type   = rec_type_acc;
        r.rec_length = len;
        if (len[31])
        begin
            r.kind   = KIND_BAD_LEN;
            msg_open = 1'b0;
            return 1'b1;
        end
        r.kind      = KIND_REC_HDR;
        payload_due = len;
        return 1'b1;
    endfunction

    function automatic void cmp_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            err_count++;
        end
    endfunction

    // appends a field to the frame, least significant byte first unless big
    function automatic void push_field(input logic [63:0] v, input int n, input bit big);
        for (int i = 0; i < n; i++)
            frame_q.push_back(big ? v[8*(n-1-i) +: 8] : v[8*i +: 8]);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic st);
        int unsigned pick;
        int unsigned gap;
        res_t        want;
        gap = 0;
        if (src_idle_on)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                gap = 0;
            else if (pick < 92)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(6, 30);
        end
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.msg_start <= st;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        if (parse_byte(b, st, want))
            due_results.push_back(want);
        bytes_sent++;
    endtask

    task automatic send_frame(input int n);
        for (int i = 0; i < n; i++)
            send_byte(frame_q[i], i == 0);
        messages_sent++;
    endtask

    task automatic test_outside_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // little-endian message: zero-length record, one-byte and two-byte payloads, then past end
    task automatic test_little_endian_records();
        frame_q.delete();
        push_field(51, 4, 1'b0);
        push_field(SWAP_LIMIT, 4, 1'b0);
        push_field(64'h8000_0000_0000_0000, 8, 1'b0);
        push_field(64'hFFFF_FFFF_FFFF_FFFF, 8, 1'b0);
        push_field(32'hFFFF_FFFF, 4, 1'b0);
        push_field(0, 4, 1'b0);
        push_field(0, 4, 1'b0);
        push_field(1, 4, 1'b0);
        frame_q.push_back(8'hFF);
        push_field(32'h7FFF_FFFF, 4, 1'b0);
        push_field(2, 4, 1'b0);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h80);
        send_frame(frame_q.size());
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
    endtask

    // big-endian message (version just over the limit when read little-endian),
    // then a negative record length that closes the message
    task automatic test_swapped_bad_length();
        frame_q.delete();
        push_field(32'h7FFF_FFFF, 4, 1'b1);
        push_field(32'h0000_0100, 4, 1'b1);
        push_field(64'h7FFF_FFFF_FFFF_FFFF, 8, 1'b1);
        push_field(0, 8, 1'b1);
        push_field(32'h1234_5678, 4, 1'b1);
        push_field(3, 4, 1'b1);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h7F);
        frame_q.push_back(8'hFF);
        push_field(32'h8000_0000, 4, 1'b1);
        push_field(32'h8000_0000, 4, 1'b1);
        send_frame(frame_q.size());
        send_byte(8'hA5, 1'b0);
        send_byte(8'h3C, 1'b0);
    endtask

    // abandoned header, total length below the header size, negative total length
    task automatic test_restart_and_odd_totals();
        frame_q.delete();
        push_field(64'h0123_4567_89AB_CDEF, 8, 1'b0);
        push_field(32'h0000_FFFF, 2, 1'b0);
        send_frame(frame_q.size());

        frame_q.delete();
        push_field(5, 4, 1'b0);
        push_field(1, 4, 1'b0);
        push_field(0, 8, 1'b0);
        push_field(0, 8, 1'b0);
        send_frame(frame_q.size());
        send_byte(8'h01, 1'b0);

        frame_q.delete();
        push_field(32'hFFFF_FFFF, 4, 1'b0);
        push_field(0, 4, 1'b0);
        push_field(64'h0F0F_0F0F_F0F0_F0F0, 8, 1'b0);
        push_field(64'hAAAA_5555_AAAA_5555, 8, 1'b0);
        send_frame(frame_q.size());
        send_byte(8'hC3, 1'b0);
    endtask

    // one random message: mostly well formed, some cut, long, bad-length or abandoned
    task automatic random_message();
        bit          big;
        int          nrec;
        int          shape;
        int          body_len;
        int          send_len;
        logic [31:0] tot;
        logic [31:0] ver;
        logic [31:0] rlen;
        frame_q.delete();
        big         = $urandom_range(0, 1);
        src_idle_on = ($urandom_range(0, 3) != 0);
        sink_stalls = ($urandom_range(0, 3) != 0);
        shape       = $urandom_range(0, 99);
        ver         = (shape < 90) ? $urandom_range(1, 16'hFFFF) : $urandom;

        push_field(0, 4, big);
        push_field(ver, 4, big);
        push_field({$urandom, $urandom}, 8, big);
        push_field({$urandom, $urandom}, 8, big);
        nrec = $urandom_range(0, 3);
        for (int i = 0; i < nrec; i++)
        begin
            rlen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10);
            push_field($urandom, 4, big);
            push_field(rlen, 4, big);
            repeat (rlen) frame_q.push_back(8'($urandom));
        end
        body_len = frame_q.size();
        send_len = body_len;

        if (shape < 60)
            tot = body_len;
        else if (shape < 70)
            tot = $urandom_range(0, body_len);
        else if (shape < 78)
        begin
            tot = body_len + $urandom_range(1, 12);
            repeat (tot - body_len + $urandom_range(0, 3)) frame_q.push_back(8'($urandom));
            send_len = frame_q.size();
        end
        else if (shape < 86)
        begin
            push_field($urandom, 4, big);
            push_field(32'h8000_0000 | $urandom, 4, big);
            repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom));
            send_len = frame_q.size();
            tot      = send_len + $urandom_range(0, 8);
        end
        else if (shape < 92)
            tot = 32'h8000_0000 | $urandom;
        else
        begin
            // cut short; the next start mark abandons it
            tot      = body_len;
            send_len = $urandom_range(1, body_len - 1);
        end

        for (int i = 0; i < 4; i++)
            frame_q[i] = big ? tot[8*(3-i) +: 8] : tot[8*i +: 8];
        send_frame(send_len);

        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic test_random_stream();
        int stop_at;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
            random_message();
    endtask

    // output receiver: random stalls, mostly short, a few long, some stall-free stretches
    always @(posedge clk)
    begin : sink_pacing
        int unsigned pick;
        if (sink_hold != 0)
            sink_hold--;
        else if (!sink_stalls)
            sink_rdy <= 1'b1;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                sink_rdy  <= 1'b1;
                sink_hold  = $urandom_range(0, 6);
            end
            else if (pick < 90)
            begin
                sink_rdy  <= 1'b0;
                sink_hold  = $urandom_range(0, 2);
            end
            else
            begin
                sink_rdy  <= 1'b0;
                sink_hold  = $urandom_range(8, 40);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            results_seen++;
            if (due_results.size() == 0)
            begin
                $error("unexpected result transfer, kind %0d", out_ch.kind);
                err_count++;
            end
            else
            begin
                want = due_results.pop_front();
                cmp_field("kind", want.kind, out_ch.kind);
                cmp_field("swapped", want.swapped, out_ch.swapped);
                cmp_field("msg_length", want.msg_length, out_ch.msg_length);
                cmp_field("version", want.version, out_ch.version);
                cmp_field("stamp", want.stamp, out_ch.stamp);
                cmp_field("sequence_res", want.sequence_res, out_ch.sequence_res);
                cmp_field("rec_type", want.rec_type, out_ch.rec_type);
                cmp_field("rec_length", want.rec_length, out_ch.rec_length);
                cmp_field("payload_byte", want.payload_byte, out_ch.payload_byte);
                cmp_field("payload_last", want.payload_last, out_ch.payload_last);
            end
        end
    end

    always @(posedge clk)
        cycle_count++;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("cycle limit reached with %0d results outstanding", due_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.msg_start <= 1'b0;
        rst_n           <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_outside_bytes();
        test_little_endian_records();
        test_swapped_bad_length();
        test_restart_and_odd_totals();
        test_random_stream();

        in_ch.valid <= 1'b0;
        sink_stalls  = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d messages, %0d bytes in, %0d results checked (LE and swapped headers,",
                 messages_sent, bytes_sent, results_seen);
        $display("  short, long, cut and negative totals, bad record lengths, bytes outside)");
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/tmd_pkg.sv
hw/rtl/tmd_if.sv
hw/rtl/tmd_front.sv
hw/rtl/tmd_fifo.sv
hw/rtl/tlv_message_deframer_top.sv
hw/rtl/tmd_checker.sv
tb/sv/tb_top.sv
